// ===== rtl/assert_macros.svh =====
// Assertion helpers; each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CBD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CBD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cbd_pkg.sv =====
package cbd_pkg;

	localparam int SIZE_BITS = 32;

	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;

	// bytes dropped after each chunk's data (the CR LF, unchecked)
	localparam int SKIP_LEN = 2;

	// progress through CR LF CR LF
	localparam logic [1:0] EM_AFTER_LINE = 2'd2;
	localparam logic [1:0] EM_LAST       = 2'd3;

	typedef enum logic [1:0] {
		PH_SIZE  = 2'd0,
		PH_DATA  = 2'd1,
		PH_SKIP  = 2'd2,
		PH_TRAIL = 2'd3
	} cbd_phase_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       chunk_last;
		logic       message_end;
	} cbd_beat_t;

	typedef struct packed {
		logic      valid;
		cbd_beat_t beat;
	} cbd_res_t;

	function automatic logic [3:0] nibble_of(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		case (b) inside
			[8'd48:8'd57]:  n = 4'(b - 8'd48);
			[8'd65:8'd70]:  n = 4'(b - 8'd55);
			[8'd97:8'd102]: n = 4'(b - 8'd87);
			default:        n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/cbd_core.sv =====
module cbd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              out_full,
	output cbd_pkg::cbd_res_t res
);

	logic                          s1_valid_q;
	logic [7:0]                    byte_s1;
	logic                          fire;

	cbd_pkg::cbd_phase_t           phase_q, phase_d;
	logic [cbd_pkg::SIZE_BITS-1:0] size_accum_q, size_accum_d;
	logic [cbd_pkg::SIZE_BITS-1:0] bytes_left_q, bytes_left_d;
	logic [cbd_pkg::SIZE_BITS-1:0] left_dec;
	logic                          cr_pending_q, cr_pending_d;
	logic [1:0]                    end_match_q, end_match_d;
	logic [7:0]                    want;

	assign fire     = s1_valid_q && !out_full;
	assign in_stall = s1_valid_q && out_full;
	assign left_dec = bytes_left_q - cbd_pkg::SIZE_BITS'(1);
	assign want     = end_match_q[0] ? cbd_pkg::CH_LF : cbd_pkg::CH_CR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

	// next state
	always_comb begin
		logic [cbd_pkg::SIZE_BITS-1:0] acc;
		acc          = size_accum_q;
		phase_d      = phase_q;
		size_accum_d = size_accum_q;
		bytes_left_d = bytes_left_q;
		cr_pending_d = cr_pending_q;
		end_match_d  = end_match_q;
		case (phase_q)
			cbd_pkg::PH_SIZE: begin
				if (cr_pending_q && byte_s1 == cbd_pkg::CH_LF) begin
					cr_pending_d = 1'b0;
					size_accum_d = '0;
					if (size_accum_q != '0) begin
						bytes_left_d = size_accum_q;
						phase_d      = cbd_pkg::PH_DATA;
					end else begin
						end_match_d = cbd_pkg::EM_AFTER_LINE;
						phase_d     = cbd_pkg::PH_TRAIL;
					end
				end else begin
					// a lone CR counts as a zero digit
					if (cr_pending_q) begin
						acc = {acc[cbd_pkg::SIZE_BITS-5:0], 4'd0};
					end
					cr_pending_d = 1'b0;
					if (byte_s1 == cbd_pkg::CH_CR) begin
						cr_pending_d = 1'b1;
					end else begin
						acc = {acc[cbd_pkg::SIZE_BITS-5:0], cbd_pkg::nibble_of(byte_s1)};
					end
					size_accum_d = acc;
				end
			end
			cbd_pkg::PH_DATA: begin
				bytes_left_d = left_dec;
				if (left_dec == '0) begin
					bytes_left_d = cbd_pkg::SIZE_BITS'(cbd_pkg::SKIP_LEN);
					phase_d      = cbd_pkg::PH_SKIP;
				end
			end
			cbd_pkg::PH_SKIP: begin
				if (bytes_left_q > cbd_pkg::SIZE_BITS'(1)) begin
					bytes_left_d = left_dec;
				end else begin
					bytes_left_d = '0;
					phase_d      = cbd_pkg::PH_SIZE;
				end
			end
			cbd_pkg::PH_TRAIL: begin
				if (byte_s1 == want) begin
					if (end_match_q == cbd_pkg::EM_LAST) begin
						end_match_d  = 2'd0;
						phase_d      = cbd_pkg::PH_SIZE;
						size_accum_d = '0;
						cr_pending_d = 1'b0;
					end else begin
						end_match_d = end_match_q + 2'd1;
					end
				end else begin
					end_match_d = (byte_s1 == cbd_pkg::CH_CR) ? 2'd1 : 2'd0;
				end
			end
			default: begin
				phase_d = cbd_pkg::PH_SIZE;
			end
		endcase
	end

	// result
	always_comb begin
		res                  = '0;
		res.beat.body_byte   = (phase_q == cbd_pkg::PH_DATA) ? byte_s1 : 8'd0;
		res.beat.chunk_last  = (phase_q == cbd_pkg::PH_DATA) && (left_dec == '0);
		res.beat.message_end = (phase_q == cbd_pkg::PH_TRAIL);
		res.valid            = fire && ((phase_q == cbd_pkg::PH_DATA) ||
			(phase_q == cbd_pkg::PH_TRAIL && end_match_q == cbd_pkg::EM_LAST &&
			byte_s1 == cbd_pkg::CH_LF));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= cbd_pkg::PH_SIZE;
			size_accum_q <= '0;
			bytes_left_q <= '0;
			cr_pending_q <= 1'b0;
			end_match_q  <= 2'd0;
		end else if (fire) begin
			phase_q      <= phase_d;
			size_accum_q <= size_accum_d;
			bytes_left_q <= bytes_left_d;
			cr_pending_q <= cr_pending_d;
			end_match_q  <= end_match_d;
		end
	end

endmodule

// ===== rtl/cbd_out_buf.sv =====
module cbd_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  cbd_pkg::cbd_res_t res,
	output logic              out_full,
	output logic              out_valid,
	input  logic              out_stall,
	output cbd_pkg::cbd_beat_t head
);

	logic [1:0]         cnt_q;
	cbd_pkg::cbd_beat_t ent0_q, ent1_q;
	logic               push, pop;

	assign push      = res.valid;
	assign pop       = (cnt_q != 2'd0) && !out_stall;
	assign out_valid = (cnt_q != 2'd0);
	assign out_full  = (cnt_q == 2'd2);
	assign head      = ent0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// a push never lands while full, so the skid entry only fills from one
	always_ff @(posedge clk) begin
		if (pop) begin
			ent0_q <= (cnt_q == 2'd2) ? ent1_q : res.beat;
		end else if (cnt_q == 2'd0 && push) begin
			ent0_q <= res.beat;
		end
		if (push && cnt_q == 2'd1 && !pop) begin
			ent1_q <= res.beat;
		end
	end

endmodule

// ===== rtl/http_chunked_body_decoder_top.sv =====
// Chunked HTTP body decoder. Takes one raw byte per beat and gives the
// decoded body bytes, the last byte of each chunk marked by chunk_last, and
// one message_end beat after the zero-size chunk and its closing blank line.
// Size lines and the two bytes after each chunk's data give no output.
// Throughput is one byte per cycle while in_stall is low. A byte taken sits in
// the input register, and its result is then registered into the two-entry
// output buffer, from which it leaves while out_stall is low.
// in_stall rises only while that output buffer is full and a byte is waiting.
`include "assert_macros.svh"

module http_chunked_body_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] body_byte,
	output logic       chunk_last,
	output logic       message_end
);

	cbd_pkg::cbd_res_t  res;
	cbd_pkg::cbd_beat_t head;
	logic               out_full;

	cbd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.out_full  (out_full),
		.res       (res)
	);

	cbd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.out_full  (out_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign body_byte   = head.body_byte;
	assign chunk_last  = head.chunk_last;
	assign message_end = head.message_end;

	`CBD_ASSERT_IMP(a_end_beat_empty, out_valid && message_end,
		!chunk_last && body_byte == 8'd0, "message-end beat carries data")
	`CBD_ASSERT_IMP(a_stall_needs_backlog, in_stall, out_valid,
		"input stalled with empty output")
	`CBD_ASSERT_IMP(a_stall_rise_cause, $rose(in_stall), $past(out_stall),
		"input stall rose without output stall")
	`CBD_ASSERT_NXT(a_stall_holds, in_stall && out_stall, in_stall,
		"input stall dropped with output blocked")

endmodule
